@@ rtl/core/vpst_pkg.sv @@
package vpst_pkg;

  // Field widths
  localparam int TEMP_W      = 11;
  localparam int LEN_W       = 9;
  localparam int DAY_W       = 9;
  localparam int HEAT_W      = 16;
  localparam int CHILL_W     = 24;
  localparam int DD_W        = 11;
  localparam int UNIT_W      = 22;
  localparam int DD_INC_W    = 12;   // (dd * len) >> 8
  localparam int CHILL_INC_W = 23;   // (unit * len) >> 8
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int ROM_DEPTH   = 1 << TEMP_W;

  localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TEMP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHILL_TARGET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HARVEST_DAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALC_LATEST_DAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_LATEST    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDBURST_SUM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VERAISON_SUM    = 3'd7;

  // Stage codes as seen on the result channel
  localparam logic [1:0] STAGE_DORMANT  = 2'd0;
  localparam logic [1:0] STAGE_BUDBURST = 2'd1;
  localparam logic [1:0] STAGE_DORMCALC = 2'd2;
  localparam logic [1:0] STAGE_REST     = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] base_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic [CHILL_W-1:0]       chill_target;
    logic [DAY_W-1:0]         harvest_day;
    logic [DAY_W-1:0]         calc_latest_day;
    logic [DAY_W-1:0]         break_latest_day;
    logic [HEAT_W-1:0]        budburst_heat_sum;
    logic [HEAT_W-1:0]        veraison_heat_sum;
  } cfg_t;

  // Item after the front stage
  typedef struct packed {
    logic [LEN_W-1:0]    step_length;
    logic [DAY_W-1:0]    day_of_year;
    logic [DD_W-1:0]     dd;
    logic [DD_INC_W-1:0] dd_inc;
  } item_a_t;

  typedef logic [UNIT_W-1:0] chill_rom_t [ROM_DEPTH];

  // Q28 fixed point used to build the chill table at elaboration
  localparam logic [63:0] FX_ONE = 64'd1 << 28;
  localparam logic [63:0] FX_CAP = 64'd1 << 35;

  function automatic logic [63:0] fx_mul(input logic [63:0] a_in, input logic [63:0] b_in);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    a = (a_in > FX_CAP) ? FX_CAP : a_in;
    b = (b_in > FX_CAP) ? FX_CAP : b_in;
    r = (a >> 28) * b + (((a & (FX_ONE - 64'd1)) * b) >> 28);
    return (r > FX_CAP) ? FX_CAP : r;
  endfunction

  function automatic logic [63:0] fx_pow(input logic [63:0] x_in, input logic [TEMP_W-1:0] e);
    logic [63:0] r;
    logic [63:0] x;
    r = FX_ONE;
    x = x_in;
    for (int i = 0; i < TEMP_W; i++) begin
      if (e[i]) r = fx_mul(r, x);
      x = fx_mul(x, x);
    end
    return r;
  endfunction

  // Largest R in [1, 2) with R^160 <= Q10
  function automatic logic [63:0] root_up(input int q10_hundredths);
    logic [63:0] a;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    a  = (64'(q10_hundredths) << 28) / 64'd100;
    lo = FX_ONE;
    hi = FX_ONE << 1;
    for (int k = 0; k < 28; k++) begin
      mid = lo + ((hi - lo) >> 1);
      if (fx_pow(mid, TEMP_W'(160)) <= a) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // floor(2^56 / r) by search on x * r <= 2^56
  function automatic logic [63:0] root_down(input logic [63:0] r);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd1 << 27;
    hi = (64'd1 << 28) + 64'd1;
    for (int k = 0; k < 32; k++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (mid * r <= (64'd1 << 56)) lo = mid;
        else hi = mid;
      end
    end
    return lo;
  endfunction

  // Chill unit per temperature code, already shifted and saturated
  function automatic chill_rom_t build_chill_rom(input int q10_hundredths);
    chill_rom_t rom;
    logic [63:0] ru;
    logic [63:0] rd;
    logic [63:0] v;
    logic signed [TEMP_W-1:0] ti;
    int tneg;
    ru = root_up(q10_hundredths);
    rd = root_down(ru);
    for (int i = 0; i < ROM_DEPTH; i++) begin
      ti   = TEMP_W'(i);
      tneg = -int'(ti);
      if (ti > 0) v = fx_pow(rd, TEMP_W'(i));
      else v = fx_pow(ru, TEMP_W'(tneg));
      v = v >> 12;
      rom[i] = (v > 64'(UNIT_MAX)) ? UNIT_MAX : v[UNIT_W-1:0];
    end
    return rom;
  endfunction

endpackage

@@ rtl/core/vpst_cfg_regs.sv @@
module vpst_cfg_regs import vpst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg_r
);

  cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_BASE_TEMP:       cfg_nxt.base_temp         = wr_data[TEMP_W-1:0];
        CFG_MAX_TEMP:        cfg_nxt.max_temp          = wr_data[TEMP_W-1:0];
        CFG_CHILL_TARGET:    cfg_nxt.chill_target      = wr_data[CHILL_W-1:0];
        CFG_HARVEST_DAY:     cfg_nxt.harvest_day       = wr_data[DAY_W-1:0];
        CFG_CALC_LATEST_DAY: cfg_nxt.calc_latest_day   = wr_data[DAY_W-1:0];
        CFG_BREAK_LATEST:    cfg_nxt.break_latest_day  = wr_data[DAY_W-1:0];
        CFG_BUDBURST_SUM:    cfg_nxt.budburst_heat_sum = wr_data[HEAT_W-1:0];
        CFG_VERAISON_SUM:    cfg_nxt.veraison_heat_sum = wr_data[HEAT_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_temp         <= 11'sd160;
      cfg_r.max_temp          <= 11'sd400;
      cfg_r.chill_target      <= 24'd1966080;
      cfg_r.harvest_day       <= 9'd100;
      cfg_r.calc_latest_day   <= 9'd60;
      cfg_r.break_latest_day  <= 9'd240;
      cfg_r.budburst_heat_sum <= 16'd5600;
      cfg_r.veraison_heat_sum <= 16'd6720;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/vpst_chill_rom.sv @@
module vpst_chill_rom import vpst_pkg::*; #(
  parameter int Q10_HUNDREDTHS = 217
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [TEMP_W-1:0] rd_addr,
  output logic [UNIT_W-1:0] rd_data_r
);

  // Chill unit per raw temperature code, filled at elaboration
  localparam chill_rom_t CHILL_ROM = build_chill_rom(Q10_HUNDREDTHS);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= CHILL_ROM[rd_addr];
    end
  end

endmodule

@@ rtl/core/vpst_dd_stage.sv @@
module vpst_dd_stage import vpst_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [TEMP_W-1:0] air_temp,
  input  logic [LEN_W-1:0]         step_length,
  input  logic [DAY_W-1:0]         day_of_year,
  input  cfg_t                     cfg,
  output item_a_t                  item_r
);

  logic signed [TEMP_W:0] diff_base;
  logic signed [TEMP_W:0] diff_cap;
  logic [DD_W-1:0]        dd;
  logic [DD_W+LEN_W-1:0]  dd_prod;
  item_a_t                item_nxt;

  // Clipped degree days for this step and its length-weighted increment
  always_comb begin
    diff_base = (TEMP_W+1)'(air_temp) - (TEMP_W+1)'(cfg.base_temp);
    diff_cap  = (TEMP_W+1)'(cfg.max_temp) - (TEMP_W+1)'(cfg.base_temp);
    if (air_temp < cfg.base_temp) begin
      dd = '0;
    end else if (air_temp >= cfg.max_temp) begin
      // cap below base counts as zero
      dd = diff_cap[TEMP_W] ? '0 : diff_cap[DD_W-1:0];
    end else begin
      dd = diff_base[DD_W-1:0];
    end
    dd_prod = dd * step_length;
    item_nxt.step_length = step_length;
    item_nxt.day_of_year = day_of_year;
    item_nxt.dd          = dd;
    item_nxt.dd_inc      = dd_prod[DD_W+LEN_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/vpst_update.sv @@
module vpst_update import vpst_pkg::*; #(
  parameter int DORMANCY_CALC_FIRST_DAY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  item_a_t            item,
  input  logic [UNIT_W-1:0]  unit,
  input  cfg_t               cfg,
  output logic [1:0]         stage_code_r,
  output logic [HEAT_W-1:0]  heat_sum_r,
  output logic [CHILL_W-1:0] chill_sum_r,
  output logic [DD_W-1:0]    step_dd_r,
  output logic [UNIT_W-1:0]  step_chill_r,
  output logic               growth_flag_r,
  output logic               maturity_flag_r
);

  typedef enum logic [1:0] {
    ST_DORMANT  = STAGE_DORMANT,
    ST_BUDBURST = STAGE_BUDBURST,
    ST_DORMCALC = STAGE_DORMCALC,
    ST_REST     = STAGE_REST
  } stage_t;

  localparam logic [DAY_W-1:0] FIRST_DAY = DAY_W'(DORMANCY_CALC_FIRST_DAY);

  stage_t                     stage_r, stage_nxt;
  logic [HEAT_W-1:0]          heat_r, heat_nxt;
  logic [CHILL_W-1:0]         chill_r, chill_nxt;
  logic                       growth_r, growth_nxt;
  logic                       mature_r, mature_nxt;
  logic                       done_r, done_nxt;

  logic                       chill_on;
  logic                       heat_on;
  logic [UNIT_W-1:0]          unit_g;
  logic [DD_W-1:0]            dd_g;
  logic [UNIT_W+LEN_W-1:0]    chill_prod;
  logic [CHILL_W:0]           chill_add;
  logic [HEAT_W:0]            heat_add;
  logic [HEAT_W:0]            heat_thr;

  always_comb begin
    // Accumulate chill in rest and dormancy calc, heat below rest
    chill_on   = (stage_r == ST_DORMCALC) || (stage_r == ST_REST);
    heat_on    = (stage_r != ST_REST);
    unit_g     = chill_on ? unit : '0;
    dd_g       = heat_on ? item.dd : '0;
    chill_prod = unit_g * item.step_length;
    chill_add  = {1'b0, chill_r} + (CHILL_W+1)'(chill_prod[UNIT_W+LEN_W-1:8]);
    heat_add   = {1'b0, heat_r} + (HEAT_W+1)'(heat_on ? item.dd_inc : '0);
    heat_thr   = {1'b0, cfg.budburst_heat_sum} + {1'b0, cfg.veraison_heat_sum};

    stage_nxt  = stage_r;
    growth_nxt = growth_r;
    mature_nxt = mature_r;
    done_nxt   = done_r;
    chill_nxt  = chill_add[CHILL_W] ? '1 : chill_add[CHILL_W-1:0];
    heat_nxt   = heat_add[HEAT_W] ? '1 : heat_add[HEAT_W-1:0];

    // Transitions, applied in order
    if (item.day_of_year >= cfg.harvest_day && stage_nxt == ST_DORMCALC) begin
      growth_nxt = 1'b0;
      heat_nxt   = '0;
      stage_nxt  = ST_REST;
    end
    if (stage_nxt == ST_REST && (chill_nxt > cfg.chill_target ||
                                 item.day_of_year >= cfg.break_latest_day)) begin
      growth_nxt = 1'b1;
      mature_nxt = 1'b0;
      chill_nxt  = '0;
      stage_nxt  = ST_DORMANT;
    end
    if (stage_nxt == ST_DORMANT && heat_nxt >= cfg.budburst_heat_sum) begin
      stage_nxt = ST_BUDBURST;
    end
    if (stage_nxt == ST_BUDBURST && !done_nxt &&
        (({1'b0, heat_nxt} >= heat_thr && item.day_of_year >= FIRST_DAY) ||
         item.day_of_year >= cfg.calc_latest_day)) begin
      mature_nxt = 1'b1;
      done_nxt   = 1'b1;
      stage_nxt  = ST_DORMCALC;
    end
    // New year clears the yearly flag
    if (item.day_of_year == '0 && done_nxt) begin
      done_nxt = 1'b0;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= ST_REST;
      heat_r   <= '0;
      chill_r  <= '0;
      growth_r <= 1'b0;
      mature_r <= 1'b0;
      done_r   <= 1'b1;
    end else if (fire) begin
      stage_r         <= stage_nxt;
      heat_r          <= heat_nxt;
      chill_r         <= chill_nxt;
      growth_r        <= growth_nxt;
      mature_r        <= mature_nxt;
      done_r          <= done_nxt;
      stage_code_r    <= stage_nxt;
      heat_sum_r      <= heat_nxt;
      chill_sum_r     <= chill_nxt;
      step_dd_r       <= dd_g;
      step_chill_r    <= unit_g;
      growth_flag_r   <= growth_nxt;
      maturity_flag_r <= mature_nxt;
    end
  end

endmodule

@@ rtl/core/vine_phenology_stage_tracker.sv @@
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------------
// in_      | input     | in_valid / in_stall | air_temp, step_length, day_of_year
// out_     | output    | out_valid/out_stall | stage_code, heat_sum, chill_sum,
//          |           |                     | step_degree_days, step_chill, flags
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while out_stall is low; an accepted item is
// registered in the front stage with the chill ROM read, then its state
// update is loaded into the result register, where it becomes valid.
// Reset is synchronous and loads the register defaults; no clearing pass.
// out_stall backs up the two stages and raises in_stall in the same cycle
// only when both stages hold an item.
module vine_phenology_stage_tracker import vpst_pkg::*; #(
  parameter int DORMANCY_CALC_FIRST_DAY = 32,
  parameter int Q10_HUNDREDTHS          = 217
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_air_temp,
  input  logic [LEN_W-1:0]         in_step_length,
  input  logic [DAY_W-1:0]         in_day_of_year,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_stage_code,
  output logic [HEAT_W-1:0]        out_heat_sum,
  output logic [CHILL_W-1:0]       out_chill_sum,
  output logic [DD_W-1:0]          out_step_degree_days,
  output logic [UNIT_W-1:0]        out_step_chill,
  output logic                     out_growth_flag,
  output logic                     out_maturity_flag,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t              cfg;
  item_a_t           item_a;
  logic [UNIT_W-1:0] unit_a;
  logic              a_valid_r, a_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              adv_a;
  logic              adv_b;
  logic              in_accept;
  logic              b_fire;

  // Pipeline flow control
  always_comb begin
    adv_b         = !out_valid_r || !out_stall;
    adv_a         = !a_valid_r || adv_b;
    in_accept     = in_valid && adv_a;
    b_fire        = a_valid_r && adv_b;
    a_valid_nxt   = adv_a ? in_valid : a_valid_r;
    out_valid_nxt = adv_b ? a_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !adv_a;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  vpst_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_r    (cfg)
  );

  vpst_chill_rom #(
    .Q10_HUNDREDTHS (Q10_HUNDREDTHS)
  ) u_rom (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (in_air_temp),
    .rd_data_r (unit_a)
  );

  vpst_dd_stage u_dd (
    .clk         (clk),
    .load        (in_accept),
    .air_temp    (in_air_temp),
    .step_length (in_step_length),
    .day_of_year (in_day_of_year),
    .cfg         (cfg),
    .item_r      (item_a)
  );

  vpst_update #(
    .DORMANCY_CALC_FIRST_DAY (DORMANCY_CALC_FIRST_DAY)
  ) u_upd (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (b_fire),
    .item            (item_a),
    .unit            (unit_a),
    .cfg             (cfg),
    .stage_code_r    (out_stage_code),
    .heat_sum_r      (out_heat_sum),
    .chill_sum_r     (out_chill_sum),
    .step_dd_r       (out_step_degree_days),
    .step_chill_r    (out_step_chill),
    .growth_flag_r   (out_growth_flag),
    .maturity_flag_r (out_maturity_flag)
  );

endmodule

@@ rtl/core/vpst_checker.sv @@
module vpst_checker import vpst_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_stage_code,
  input logic [HEAT_W-1:0]  out_heat_sum,
  input logic [CHILL_W-1:0] out_chill_sum,
  input logic               out_growth_flag,
  input logic               out_maturity_flag
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stage_code) &&
      $stable(out_heat_sum) && $stable(out_chill_sum))
    else $error("result changed while stalled");

  // Rest is only entered through harvest or reset: no growth, no heat
  a_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stage_code == STAGE_REST |->
      !out_growth_flag && out_heat_sum == '0)
    else $error("rest stage with growth or heat");

  // Dormant and budburst follow dormancy start: growing, immature, chill cleared
  a_growing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stage_code == STAGE_DORMANT || out_stage_code == STAGE_BUDBURST) |->
      out_growth_flag && !out_maturity_flag && out_chill_sum == '0)
    else $error("dormant or budburst flags wrong");

  // Dormancy calculation is entered with maturity set
  a_dormcalc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stage_code == STAGE_DORMCALC |-> out_growth_flag && out_maturity_flag)
    else $error("dormancy calc without maturity");

endmodule

bind vine_phenology_stage_tracker vpst_checker u_vpst_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_stage_code       (out_stage_code),
  .out_heat_sum         (out_heat_sum),
  .out_chill_sum        (out_chill_sum),
  .out_growth_flag      (out_growth_flag),
  .out_maturity_flag    (out_maturity_flag)
);
